/* hdl/tsh_pkg.sv */
// Shared constants for the triangle barycentric shader.
package tsh_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS_DEF = 8;
    localparam int NUM_VERTS      = 3;
    localparam int NUM_CHANS      = 3;

    localparam logic       REQ_LOAD  = 1'b0;
    localparam logic       REQ_QUERY = 1'b1;
    localparam logic [1:0] SLOT_NONE = 2'd3;

endpackage

/* hdl/triangle_barycentric_shader.sv */
// Triangle shader: vertex store, barycentric inside test and colour interpolation pipeline.
// A load beat to slot 0, 1 or 2 writes one vertex (x, y, colour) at once and gives no
// result; a query beat gives one result. One beat enters every cycle unless in_stall is high.
// The edge that accepts a query loads the first of five stages of differences, products,
// edge sums, sign fix with inside test and colour products, then one stage of colour sums,
// then a restoring divider that settles one quotient bit per stage. A query sees the
// vertices as they stand when it is accepted. A stalled output holds the whole pipeline.
module triangle_barycentric_shader #(
    parameter int COORD_BITS = tsh_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = tsh_pkg::COLOR_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         req_type,
    input  logic [1:0]                   vertex_slot,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic [COLOR_BITS-1:0]        red_in,
    input  logic [COLOR_BITS-1:0]        green_in,
    input  logic [COLOR_BITS-1:0]        blue_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         inside_res,
    output logic [COLOR_BITS-1:0]        red_out,
    output logic [COLOR_BITS-1:0]        green_out,
    output logic [COLOR_BITS-1:0]        blue_out
);

    localparam int NV = tsh_pkg::NUM_VERTS;
    localparam int NC = tsh_pkg::NUM_CHANS;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int WB = PW + 2;
    localparam int NB = WB + COLOR_BITS + 2;
    localparam int NS = COLOR_BITS;

    logic                         en;
    logic                         accept;
    logic                         load_we;

    logic signed [COORD_BITS-1:0] vx_reg [NV];
    logic signed [COORD_BITS-1:0] vy_reg [NV];
    logic [COLOR_BITS-1:0]        vc_reg [NV][NC];
    logic signed [DW-1:0]         vxe [NV];
    logic signed [DW-1:0]         vye [NV];
    logic signed [DW-1:0]         pxe;
    logic signed [DW-1:0]         pye;

    logic [COLOR_BITS-1:0]        col_reg [4][NV][NC];
    logic [4:0]                   sv_reg;

    logic signed [DW-1:0]         s1_a_reg, s1_b_reg, s1_e_reg, s1_f_reg, s1_dx_reg, s1_dy_reg;
    logic signed [PW-1:0]         s2_af_reg, s2_be_reg, s2_adx_reg, s2_bdy_reg;
    logic signed [PW-1:0]         s2_edx_reg, s2_fdy_reg;
    logic signed [WB-1:0]         s3_d_reg, s3_w0_reg, s3_w1_reg;

    logic signed [WB-1:0]         s4_w2;
    logic signed [WB-1:0]         s4_dn;
    logic signed [WB-1:0]         s4_wn [NV];
    logic                         s4_in_next;
    logic [WB-1:0]                s4_d_reg;
    logic [WB-1:0]                s4_w_reg [NV];
    logic                         s4_in_reg;

    logic [NB-1:0]                s5_m_reg [NV][NC];
    logic [WB-1:0]                s5_d_reg;
    logic                         s5_in_reg;

    logic [NB-1:0]                dv_rem_reg [NS+1][NC];
    logic [NS-1:0]                dv_q_reg   [NS+1][NC];
    logic [WB-1:0]                dv_d_reg   [NS+1];
    logic                         dv_in_reg  [NS+1];
    logic                         dv_v_reg   [NS+1];

    assign en       = !(dv_v_reg[NS] && out_stall);
    assign in_stall = !en;
    assign accept   = in_valid && en;
    assign load_we  = accept && (req_type == tsh_pkg::REQ_LOAD)
                      && (vertex_slot != tsh_pkg::SLOT_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NV; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
                for (int k = 0; k < NC; k++)
                    vc_reg[i][k] <= '0;
            end
        end
        else if (load_we)
        begin
            vx_reg[vertex_slot] <= coord_x;
            vy_reg[vertex_slot] <= coord_y;
            vc_reg[vertex_slot][0] <= red_in;
            vc_reg[vertex_slot][1] <= green_in;
            vc_reg[vertex_slot][2] <= blue_in;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NV; i++)
        begin
            vxe[i] = DW'(vx_reg[i]);
            vye[i] = DW'(vy_reg[i]);
        end
        pxe = DW'(coord_x);
        pye = DW'(coord_y);
    end

    always_comb
    begin
        s4_w2    = s3_d_reg - s3_w0_reg - s3_w1_reg;
        s4_dn    = s3_d_reg[WB-1] ? -s3_d_reg : s3_d_reg;
        s4_wn[0] = s3_d_reg[WB-1] ? -s3_w0_reg : s3_w0_reg;
        s4_wn[1] = s3_d_reg[WB-1] ? -s3_w1_reg : s3_w1_reg;
        s4_wn[2] = s3_d_reg[WB-1] ? -s4_w2 : s4_w2;
        s4_in_next = (s3_d_reg != '0);
        for (int i = 0; i < NV; i++)
            if (s4_wn[i] < 0 || s4_wn[i] > s4_dn)
                s4_in_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= '0;
        end
        else if (en)
        begin
            sv_reg <= {sv_reg[3:0], in_valid && (req_type == tsh_pkg::REQ_QUERY)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_a_reg  <= vye[1] - vye[2];
            s1_b_reg  <= vxe[2] - vxe[1];
            s1_e_reg  <= vye[2] - vye[0];
            s1_f_reg  <= vxe[0] - vxe[2];
            s1_dx_reg <= pxe - vxe[2];
            s1_dy_reg <= pye - vye[2];
            col_reg[0] <= vc_reg;
            for (int s = 1; s < 4; s++)
                col_reg[s] <= col_reg[s-1];

            s2_af_reg  <= s1_a_reg * s1_f_reg;
            s2_be_reg  <= s1_b_reg * s1_e_reg;
            s2_adx_reg <= s1_a_reg * s1_dx_reg;
            s2_bdy_reg <= s1_b_reg * s1_dy_reg;
            s2_edx_reg <= s1_e_reg * s1_dx_reg;
            s2_fdy_reg <= s1_f_reg * s1_dy_reg;

            s3_d_reg  <= WB'(s2_af_reg) - WB'(s2_be_reg);
            s3_w0_reg <= WB'(s2_adx_reg) + WB'(s2_bdy_reg);
            s3_w1_reg <= WB'(s2_edx_reg) + WB'(s2_fdy_reg);

            s4_d_reg  <= s4_dn;
            s4_in_reg <= s4_in_next;
            for (int i = 0; i < NV; i++)
                s4_w_reg[i] <= s4_in_next ? s4_wn[i] : '0;

            s5_d_reg  <= s4_d_reg;
            s5_in_reg <= s4_in_reg;
            for (int i = 0; i < NV; i++)
                for (int k = 0; k < NC; k++)
                    s5_m_reg[i][k] <= NB'(s4_w_reg[i]) * NB'(col_reg[3][i][k]);

            dv_d_reg[0]  <= s5_d_reg;
            dv_in_reg[0] <= s5_in_reg;
            for (int k = 0; k < NC; k++)
            begin
                dv_rem_reg[0][k] <= s5_m_reg[0][k] + s5_m_reg[1][k] + s5_m_reg[2][k];
                dv_q_reg[0][k]   <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (en)
            dv_v_reg[0] <= sv_reg[4];
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_div
        localparam int K = NS - 1 - j;
        logic [NB-1:0] trial;
        logic [NB-1:0] rem_next [NC];
        logic [NS-1:0] q_next   [NC];

        always_comb
        begin
            trial = NB'(dv_d_reg[j]) << K;
            for (int k = 0; k < NC; k++)
            begin
                rem_next[k] = dv_rem_reg[j][k];
                q_next[k]   = dv_q_reg[j][k];
                if (dv_rem_reg[j][k] >= trial)
                begin
                    rem_next[k] = dv_rem_reg[j][k] - trial;
                    q_next[k][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_d_reg[j+1]  <= dv_d_reg[j];
                dv_in_reg[j+1] <= dv_in_reg[j];
                dv_rem_reg[j+1] <= rem_next;
                dv_q_reg[j+1]   <= q_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j+1] <= 1'b0;
            else if (en)
                dv_v_reg[j+1] <= dv_v_reg[j];
        end
    end

    assign out_valid  = dv_v_reg[NS];
    assign inside_res = dv_in_reg[NS];
    assign red_out    = dv_in_reg[NS] ? dv_q_reg[NS][0] : '0;
    assign green_out  = dv_in_reg[NS] ? dv_q_reg[NS][1] : '0;
    assign blue_out   = dv_in_reg[NS] ? dv_q_reg[NS][2] : '0;

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall without a blocked output");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && req_type == tsh_pkg::REQ_LOAD) |=> !sv_reg[0])
        else $error("load beat entered the result pipeline");

    a_zero_det_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (en && s3_d_reg == '0) |=> !s4_in_reg)
        else $error("degenerate triangle reported inside");

    a_held_output: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(inside_res) && $stable(red_out)))
        else $error("stalled result changed");

endmodule
